### hw/rtl/abc_pkg.sv
// Package: shared types and cadence constants for the alarm beeper block.
package abc_pkg;

  localparam int unsigned CadW = 13;
  localparam int unsigned LenW = 16;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [LenW-1:0]  beep_length_ms;
    logic             preflight_fail;
    logic             fence_alarm;
    logic             low_battery;
    logic             alt_hold_alarm;
    logic             in_shutdown;
    logic             throttle_check;
    logic             descending;
  } in_item_t;

  typedef struct packed {
    logic beeper_level;
    logic alarm_active;
  } out_item_t;

  localparam logic [CadW-1:0] FenceOn   = CadW'(250);
  localparam logic [CadW-1:0] FenceOff  = CadW'(3000);
  localparam logic [CadW-1:0] LowBatOn  = CadW'(600);
  localparam logic [CadW-1:0] LowBatOff = CadW'(600);
  localparam logic [CadW-1:0] AltOn     = CadW'(1000);
  localparam logic [CadW-1:0] AltOff    = CadW'(1000);
  localparam logic [CadW-1:0] ShutOn    = CadW'(250);
  localparam logic [CadW-1:0] ShutOff   = CadW'(4750);
  localparam logic [CadW-1:0] DefOn     = CadW'(125);
  localparam logic [CadW-1:0] DefOff    = CadW'(125);

endpackage

### hw/rtl/abc_if.sv
// Interfaces: valid/ready channels for input items and result items.
interface abc_in_if (input logic clk);
  logic              valid;
  logic              ready;
  abc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abc_out_if (input logic clk);
  logic               valid;
  logic               ready;
  abc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/alarm_beeper_cadence.sv
// Top level: alarm beeper cadence controller with registered result stage.
//
//  channel  | dir | payload                                  | transaction when
//  in_ch    | in  | operation, beep_length_ms, 7 alarm flags | valid && ready
//  out_ch   | out | beeper_level, alarm_active               | valid && ready
//
// Each transaction updates state in the cycle it is accepted; its result sits
// in the output register from the next cycle on. One transaction per cycle while out_ch is not stalled.
// in_ch.ready is high while the output register is empty or being drained.
// Synchronous active-low reset: timers expired, beeper off, no alarm.
module alarm_beeper_cadence (
  input logic      clk,
  input logic      rst_n,
  abc_in_if.sink   in_ch,
  abc_out_if.source out_ch
);

  logic [abc_pkg::CadW-1:0] cad_r, cad_nxt;
  logic [abc_pkg::LenW-1:0] shot_r, shot_nxt;
  logic                     beep_r, beep_nxt;
  logic                     own_r, own_nxt;
  logic                     oval_r, oval_nxt;
  abc_pkg::out_item_t       odata_r;

  abc_pkg::in_item_t        it;
  logic                     acc;
  logic                     any_alarm;
  logic [abc_pkg::CadW-1:0] cad_dec, on_t, off_t;
  logic [abc_pkg::LenW-1:0] shot_dec;

  assign it  = in_ch.data;
  assign in_ch.ready = !oval_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;

  assign out_ch.valid = oval_r;
  assign out_ch.data  = odata_r;

  assign any_alarm = it.preflight_fail || it.fence_alarm || it.low_battery ||
                     it.alt_hold_alarm || it.in_shutdown || it.throttle_check ||
                     it.descending;
  assign cad_dec  = (cad_r != '0) ? cad_r - 1'b1 : cad_r;
  assign shot_dec = (shot_r != '0) ? shot_r - 1'b1 : shot_r;

  // cadence priority: fence, low battery, alt hold, shutdown, other
  always_comb begin
    if (it.fence_alarm) begin
      on_t = abc_pkg::FenceOn;  off_t = abc_pkg::FenceOff;
    end else if (it.low_battery) begin
      on_t = abc_pkg::LowBatOn; off_t = abc_pkg::LowBatOff;
    end else if (it.alt_hold_alarm) begin
      on_t = abc_pkg::AltOn;    off_t = abc_pkg::AltOff;
    end else if (it.in_shutdown) begin
      on_t = abc_pkg::ShutOn;   off_t = abc_pkg::ShutOff;
    end else begin
      on_t = abc_pkg::DefOn;    off_t = abc_pkg::DefOff;
    end
  end

  always_comb begin
    cad_nxt  = cad_r;
    shot_nxt = shot_r;
    beep_nxt = beep_r;
    own_nxt  = own_r;
    oval_nxt = oval_r && !out_ch.ready;
    if (acc) begin
      oval_nxt = 1'b1;
      case (it.operation)
        abc_pkg::OP_SCHEDULE: begin
          if (!own_r) begin
            beep_nxt = 1'b1;
            shot_nxt = it.beep_length_ms;
          end
        end
        default: begin
          cad_nxt  = cad_dec;
          shot_nxt = shot_dec;
          own_nxt  = any_alarm;
          if (any_alarm) begin
            if (cad_dec == '0) begin
              beep_nxt = !beep_r;
              cad_nxt  = beep_r ? off_t : on_t;
            end
          end else if (shot_dec == '0) begin
            beep_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cad_r  <= '0;
      shot_r <= '0;
      beep_r <= 1'b0;
      own_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      cad_r  <= cad_nxt;
      shot_r <= shot_nxt;
      beep_r <= beep_nxt;
      own_r  <= own_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      odata_r.beeper_level <= beep_nxt;
      odata_r.alarm_active <= own_nxt;
    end
  end

  // a stalled result must not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && !out_ch.ready |=> oval_r && $stable(odata_r))
    else $error("result changed while stalled");

  // output register tracks current beeper and ownership state
  a_track: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> odata_r.beeper_level == beep_r && odata_r.alarm_active == own_r)
    else $error("result disagrees with state");

  // a schedule never clears the alarm ownership or changes cadence timer
  a_sched: assert property (@(posedge clk) disable iff (!rst_n)
    acc && it.operation == abc_pkg::OP_SCHEDULE |=>
      own_r == $past(own_r) && cad_r == $past(cad_r))
    else $error("schedule disturbed alarm state");

  // cadence timer never exceeds the longest off time
  a_cad: assert property (@(posedge clk) disable iff (!rst_n)
    cad_r <= abc_pkg::ShutOff)
    else $error("cadence timer out of range");

endmodule

### tb/tb.sv
// Testbench for alarm_beeper_cadence: self-checking, with predictor, stalls and hold-offs.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned ItemTarget    = 950;

  typedef logic [abc_pkg::LenW-1:0] len_t;

  // Alarm flag bits, packed as {preflight, fence, lowbat, althold, shutdown, throttle, descent}
  localparam logic [6:0] PreflightFlag = 7'h40;
  localparam logic [6:0] FenceFlag     = 7'h20;
  localparam logic [6:0] LowBatFlag    = 7'h10;
  localparam logic [6:0] AltHoldFlag   = 7'h08;
  localparam logic [6:0] ShutdownFlag  = 7'h04;
  localparam logic [6:0] ThrottleFlag  = 7'h02;
  localparam logic [6:0] DescentFlag   = 7'h01;

  class cadence_scoreboard;
    logic [abc_pkg::CadW-1:0] cad_left;
    logic [abc_pkg::LenW-1:0] shot_left;
    logic                     beeping;
    logic                     alarm_owned;
    abc_pkg::out_item_t       due_levels[$];
    int unsigned              mismatches;

    function new();
      cad_left    = '0;
      shot_left   = '0;
      beeping     = 1'b0;
      alarm_owned = 1'b0;
      mismatches  = 0;
    endfunction

    function void note_accepted(abc_pkg::in_item_t it);
      logic [abc_pkg::CadW-1:0] on_ms;
      logic [abc_pkg::CadW-1:0] off_ms;
      abc_pkg::out_item_t       due;
      if (it.operation == abc_pkg::OP_SCHEDULE) begin
        if (!alarm_owned) begin
          beeping   = 1'b1;
          shot_left = it.beep_length_ms;
        end
      end else begin
        if (cad_left != '0) cad_left = cad_left - 1'b1;
        if (shot_left != '0) shot_left = shot_left - 1'b1;
        alarm_owned = it.preflight_fail | it.fence_alarm | it.low_battery |
                      it.alt_hold_alarm | it.in_shutdown | it.throttle_check |
                      it.descending;
        if (alarm_owned) begin
          if (it.fence_alarm) begin
            on_ms = abc_pkg::FenceOn;  off_ms = abc_pkg::FenceOff;
          end else if (it.low_battery) begin
            on_ms = abc_pkg::LowBatOn; off_ms = abc_pkg::LowBatOff;
          end else if (it.alt_hold_alarm) begin
            on_ms = abc_pkg::AltOn;    off_ms = abc_pkg::AltOff;
          end else if (it.in_shutdown) begin
            on_ms = abc_pkg::ShutOn;   off_ms = abc_pkg::ShutOff;
          end else begin
            on_ms = abc_pkg::DefOn;    off_ms = abc_pkg::DefOff;
          end
          if (cad_left == '0) begin
            cad_left = beeping ? off_ms : on_ms;
            beeping  = !beeping;
          end
        end else if (shot_left == '0) begin
          beeping = 1'b0;
        end
      end
      due.beeper_level = beeping;
      due.alarm_active = alarm_owned;
      due_levels.push_back(due);
    endfunction

    function void check_level(abc_pkg::out_item_t got);
      abc_pkg::out_item_t due;
      if (due_levels.size() == 0) begin
        $error("unexpected result transaction: beeper_level %0b alarm_active %0b",
               got.beeper_level, got.alarm_active);
        mismatches++;
        return;
      end
      due = due_levels.pop_front();
      if (got.beeper_level !== due.beeper_level) begin
        $error("beeper_level: expected %0b, got %0b", due.beeper_level, got.beeper_level);
        mismatches++;
      end
      if (got.alarm_active !== due.alarm_active) begin
        $error("alarm_active: expected %0b, got %0b", due.alarm_active, got.alarm_active);
        mismatches++;
      end
    endfunction

    function int unsigned levels_pending();
      return due_levels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  abc_in_if  in_ch (clk);
  abc_out_if out_ch (clk);

  alarm_beeper_cadence dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cadence_scoreboard sb;
  bit          sender_gaps = 1'b1;
  bit          recv_gaps   = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned items_sent  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** alarm_beeper_cadence: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_accepted(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_level(out_ch.data);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready <= !(recv_gaps && $urandom_range(0, 99) < 32);
    end
  end

  function automatic abc_pkg::in_item_t make_item(abc_pkg::op_t op, len_t len,
                                                  logic [6:0] flags);
    abc_pkg::in_item_t it;
    it.operation      = op;
    it.beep_length_ms = len;
    it.preflight_fail = flags[6];
    it.fence_alarm    = flags[5];
    it.low_battery    = flags[4];
    it.alt_hold_alarm = flags[3];
    it.in_shutdown    = flags[2];
    it.throttle_check = flags[1];
    it.descending     = flags[0];
    return it;
  endfunction

  task automatic drive_item(input abc_pkg::in_item_t it);
    // one stretch with no stalls on either side
    sender_gaps = !(items_sent >= 420 && items_sent < 580);
    recv_gaps   = sender_gaps;
    if (sender_gaps) begin
      while ($urandom_range(0, 99) < 32) begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= abc_pkg::in_item_t'($urandom);
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_tick(input logic [6:0] flags);
    drive_item(make_item(abc_pkg::OP_TICK, len_t'($urandom), flags));
    items_sent++;
  endtask

  task automatic send_schedule(input len_t len, input logic [6:0] flags);
    drive_item(make_item(abc_pkg::OP_SCHEDULE, len, flags));
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.levels_pending() != 0) @(posedge clk);
  endtask

  // Steady alarm with an occasional schedule (ignored while the alarm owns the beeper) or a noise tick
  task automatic alarm_run(input int unsigned len);
    logic [6:0] flags;
    flags = 7'(1 << $urandom_range(0, 6));
    if ($urandom_range(0, 3) == 0) flags |= 7'($urandom);
    repeat (len) begin
      if (items_sent >= ItemTarget) break;
      if ($urandom_range(0, 39) == 0)
        send_schedule(len_t'($urandom), 7'($urandom));
      if ($urandom_range(0, 49) == 0) send_tick(7'($urandom));
      else send_tick(flags);
    end
  endtask

  // No alarm: one-shot beeps, mostly short, sometimes rescheduled mid-beep
  task automatic oneshot_run(input int unsigned beeps);
    len_t        len;
    int unsigned ticks;
    repeat (beeps) begin
      if (items_sent >= ItemTarget) break;
      len = ($urandom_range(0, 7) == 0) ? len_t'($urandom) : len_t'($urandom_range(0, 40));
      send_schedule(len, 7'($urandom));
      ticks = $urandom_range(0, 60);
      repeat (ticks) begin
        if (items_sent >= ItemTarget) break;
        if ($urandom_range(0, 14) == 0) send_schedule(len_t'($urandom_range(0, 20)), '0);
        else send_tick('0);
      end
    end
  endtask

  task automatic noise_run(input int unsigned len);
    repeat (len) begin
      if (items_sent >= ItemTarget) break;
      if ($urandom_range(0, 1) == 0) send_tick(7'($urandom));
      else send_schedule(len_t'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    bit held_off;
    bit paused;
    sb = new();
    held_off = 1'b0;
    paused   = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    send_tick('0);
    send_schedule('0, '0);                  // zero-length beep
    send_tick('0);
    send_schedule('1, 7'h7F);               // full-length beep, flags ignored
    send_tick('0);
    send_schedule(16'd3, '0);               // reload while sounding
    repeat (4) send_tick('0);
    send_tick(PreflightFlag);
    send_schedule(16'd100, '0);             // ignored, alarm owns the beeper
    send_tick(7'h7F);
    send_tick(LowBatFlag | AltHoldFlag | ShutdownFlag);
    send_tick(AltHoldFlag | ShutdownFlag | ThrottleFlag);
    send_tick(ShutdownFlag | DescentFlag);
    send_tick(ThrottleFlag);
    send_tick(DescentFlag);
    send_tick(FenceFlag);
    send_tick('0);                          // alarm drops mid-cadence
    send_schedule(16'hAAAA, '0);
    send_tick(DescentFlag);
    send_tick('0);                          // one-shot still running, level held
    send_schedule(16'h5555, '0);
    send_tick('0);

    // Random part
    while (items_sent < ItemTarget) begin
      if (!held_off && items_sent >= 300) begin
        held_off     = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!paused && items_sent >= 650) begin
        paused = 1'b1;
        drain_results();
        @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: alarm_run($urandom_range(20, 200));
        6, 7, 8:          oneshot_run($urandom_range(1, 4));
        default:          noise_run($urandom_range(5, 30));
      endcase
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.levels_pending() == 0) begin
      $display("** alarm_beeper_cadence: PASSED **");
    end else begin
      $display("** alarm_beeper_cadence: FAILED **");
    end
    $finish;
  end

endmodule
